// ----- hdl/etap_pkg.sv -----
// Package: shared types and constants for the edge taper apodization block.
package etap_pkg;

   // Field and register widths
   localparam int PixelW    = 16;
   localparam int DistW     = 16;
   localparam int FracW     = 4;
   localparam int IdxW      = DistW - FracW;
   localparam int KW        = 11;
   localparam int FrameDimW = 13;
   localparam int TaperW    = 10;
   localparam int InvW      = 17;
   localparam int WeightW   = 17;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 17;

   // Shared multiplier operand and product widths
   localparam int MulW  = 18;
   localparam int ProdW = 2 * MulW;

   // Q1.16 / Q2.16 constants
   localparam logic [WeightW-1:0] OneQ16   = 17'd65536;
   localparam logic [MulW-1:0]    ThreeQ16 = 18'd196608;
   localparam logic [33:0]        RoundQ16 = 34'd32768;
   localparam logic [PixelW-1:0]  PixelMax = 16'hFFFF;
   localparam logic [FracW:0]     FracOne  = 5'd16;

   // Queue between front and back
   localparam int QueueDepth  = 4;
   localparam int QueuePtrW   = $clog2(QueueDepth);
   localparam int QueueCountW = $clog2(QueueDepth + 1);

   typedef enum logic [CsrIndexW-1:0] {
      REG_FRAME_WIDTH   = 3'd0,
      REG_FRAME_HEIGHT  = 3'd1,
      REG_TAPER_SIZE    = 3'd2,
      REG_TAPER_INVERSE = 3'd3,
      REG_MASKED_MODE   = 3'd4
   } etap_reg_type;

   typedef enum logic [1:0] {
      KIND_PASS  = 2'd0,
      KIND_ZERO  = 2'd1,
      KIND_TAPER = 2'd2
   } etap_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE   = 3'd0,
      BK_T      = 3'd1,
      BK_T2     = 3'd2,
      BK_W      = 3'd3,
      BK_BLEND0 = 3'd4,
      BK_BLEND1 = 3'd5,
      BK_SCALE  = 3'd6
   } etap_back_state_type;

   typedef struct packed {
      logic [PixelW-1:0] pixel_value;
      logic [DistW-1:0]  edge_distance;
   } etap_req_type;

   typedef struct packed {
      logic [PixelW-1:0] tapered_value;
      logic              frame_end;
   } etap_rsp_type;

   typedef struct packed {
      logic [FrameDimW-1:0] frame_width;
      logic [FrameDimW-1:0] frame_height;
      logic [TaperW-1:0]    taper_size;
      logic [InvW-1:0]      taper_inverse;
      logic                 masked_mode;
   } etap_cfg_type;

   typedef struct packed {
      etap_kind_type     kind;
      logic              blend;
      logic [KW-1:0]     k;
      logic [FracW-1:0]  frac;
      logic [PixelW-1:0] pixel;
      logic              frame_end;
   } etap_entry_type;

   typedef struct packed {
      logic [QueueCountW-1:0] count;
      logic                   full;
      logic                   empty;
   } etap_queue_status_type;

endpackage

// ----- hdl/etap_front.sv -----
// Front end: frame counters, edge distance and request classification.
module etap_front #(
   parameter int MAX_DIM = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  etap_pkg::etap_req_type req_data,
   input  etap_pkg::etap_cfg_type cfg,
   input  logic                   queue_full,
   output logic                   req_stall,
   output logic                   push,
   output etap_pkg::etap_entry_type push_entry
);

   localparam int CntW = $clog2(MAX_DIM);
   localparam int DimW = (CntW + 1 > etap_pkg::FrameDimW) ? CntW + 1 : etap_pkg::FrameDimW;

   logic [CntW-1:0] col_ff, col_in;
   logic [CntW-1:0] row_ff, row_in;

   logic [DimW-1:0] fw_raw, fh_raw, fw, fh;
   logic [DimW-1:0] col_x, row_x, right, bottom, dmin_h, dmin_v, dmin;
   logic [DimW-1:0] taper_x;
   logic            last_col, last_row;
   logic [etap_pkg::IdxW-1:0] idx;

   always_comb begin
      fw_raw = DimW'(cfg.frame_width);
      fh_raw = DimW'(cfg.frame_height);
      if (fw_raw == '0) fw = DimW'(1);
      else if (fw_raw > DimW'(MAX_DIM)) fw = DimW'(MAX_DIM);
      else fw = fw_raw;
      if (fh_raw == '0) fh = DimW'(1);
      else if (fh_raw > DimW'(MAX_DIM)) fh = DimW'(MAX_DIM);
      else fh = fh_raw;

      col_x    = DimW'(col_ff);
      row_x    = DimW'(row_ff);
      last_col = (col_x + DimW'(1)) >= fw;
      last_row = (row_x + DimW'(1)) >= fh;
      right    = (col_x < fw) ? (fw - DimW'(1) - col_x) : '0;
      bottom   = (row_x < fh) ? (fh - DimW'(1) - row_x) : '0;
      dmin_h   = (col_x < right) ? col_x : right;
      dmin_v   = (row_x < bottom) ? row_x : bottom;
      dmin     = (dmin_h < dmin_v) ? dmin_h : dmin_v;
      taper_x  = DimW'(cfg.taper_size);
      idx      = req_data.edge_distance[etap_pkg::DistW-1:etap_pkg::FracW];

      push_entry.pixel     = req_data.pixel_value;
      push_entry.frame_end = last_col && last_row;
      push_entry.frac      = req_data.edge_distance[etap_pkg::FracW-1:0];
      push_entry.blend     = cfg.masked_mode;
      push_entry.k         = '0;
      push_entry.kind      = etap_pkg::KIND_PASS;

      if (cfg.taper_size != '0) begin
         if (cfg.masked_mode) begin
            if (req_data.edge_distance == '0) begin
               push_entry.kind = etap_pkg::KIND_ZERO;
            end else if (idx < etap_pkg::IdxW'(cfg.taper_size)) begin
               push_entry.kind = etap_pkg::KIND_TAPER;
               push_entry.k    = idx[etap_pkg::KW-1:0];
            end
         end else if (dmin < taper_x) begin
            push_entry.kind = etap_pkg::KIND_TAPER;
            push_entry.k    = dmin[etap_pkg::KW-1:0];
         end
      end

      req_stall = queue_full;
      push      = req_valid && !queue_full;

      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + CntW'(1);
         end else begin
            col_in = col_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ----- hdl/etap_queue.sv -----
// Short request queue between front and back.
module etap_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  etap_pkg::etap_entry_type        push_entry,
   input  logic                            pop,
   output etap_pkg::etap_entry_type        head,
   output etap_pkg::etap_queue_status_type status
);

   etap_pkg::etap_entry_type entry_ff [etap_pkg::QueueDepth];

   logic [etap_pkg::QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [etap_pkg::QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [etap_pkg::QueueCountW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + etap_pkg::QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + etap_pkg::QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff + etap_pkg::QueueCountW'(push) - etap_pkg::QueueCountW'(pop);

      head         = entry_ff[rd_ptr_ff];
      status.count = count_ff;
      status.full  = count_ff == etap_pkg::QueueCountW'(etap_pkg::QueueDepth);
      status.empty = count_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- hdl/etap_back.sv -----
// Back end: smoothstep weight sequencer on one shared multiplier, output register.
module etap_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [etap_pkg::InvW-1:0]           taper_inverse,
   input  etap_pkg::etap_entry_type            head,
   input  etap_pkg::etap_queue_status_type     queue_status,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output etap_pkg::etap_rsp_type              rsp_data
);

   localparam int MulW  = etap_pkg::MulW;
   localparam int ProdW = etap_pkg::ProdW;
   localparam int WW    = etap_pkg::WeightW;
   localparam int AccW  = 22;

   etap_pkg::etap_back_state_type state_ff, state_in;

   logic [etap_pkg::KW-1:0]     k_ff, k_in;
   logic [etap_pkg::FracW-1:0]  frac_ff, frac_in;
   logic                        blend_ff, blend_in;
   logic                        second_ff, second_in;
   logic [etap_pkg::PixelW-1:0] pixel_ff, pixel_in;
   logic                        fend_ff, fend_in;
   logic [WW-1:0]               t_ff, t_in;
   logic [WW-1:0]               t2_ff, t2_in;
   logic [WW-1:0]               w0_ff, w0_in;
   logic [WW-1:0]               w1_ff, w1_in;
   logic [AccW-1:0]             acc_ff, acc_in;
   logic [WW-1:0]               wt_ff, wt_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   etap_pkg::etap_rsp_type      rsp_data_ff, rsp_data_in;

   logic [MulW-1:0]  mul_a, mul_b;
   logic [ProdW-1:0] prod;
   logic [MulW-1:0]  s_val;
   logic [WW-1:0]    w_new;
   logic [AccW-1:0]  blend_sum;
   logic [33:0]      scaled;
   logic             out_free;

   always_comb begin
      s_val = etap_pkg::ThreeQ16 - {t_ff, 1'b0};
      unique case (state_ff)
         etap_pkg::BK_T: begin
            mul_a = MulW'(k_ff);
            mul_b = MulW'(taper_inverse);
         end
         etap_pkg::BK_T2: begin
            mul_a = MulW'(t_ff);
            mul_b = MulW'(t_ff);
         end
         etap_pkg::BK_W: begin
            mul_a = MulW'(t2_ff);
            mul_b = s_val;
         end
         etap_pkg::BK_BLEND0: begin
            mul_a = MulW'(w0_ff);
            mul_b = MulW'(etap_pkg::FracOne - (etap_pkg::FracW + 1)'(frac_ff));
         end
         etap_pkg::BK_BLEND1: begin
            mul_a = MulW'(w1_ff);
            mul_b = MulW'(frac_ff);
         end
         etap_pkg::BK_SCALE: begin
            mul_a = MulW'(pixel_ff);
            mul_b = MulW'(wt_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = ProdW'(mul_a) * ProdW'(mul_b);
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      frac_in      = frac_ff;
      blend_in     = blend_ff;
      second_in    = second_ff;
      pixel_in     = pixel_ff;
      fend_in      = fend_ff;
      t_in         = t_ff;
      t2_in        = t2_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      acc_in       = acc_ff;
      wt_in        = wt_ff;
      rsp_data_in  = rsp_data_ff;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop          = 1'b0;

      w_new     = (prod[ProdW-1:16] > 20'(etap_pkg::OneQ16)) ? etap_pkg::OneQ16
                                                             : prod[32:16];
      blend_sum = acc_ff + prod[AccW-1:0];
      scaled    = prod[33:0] + etap_pkg::RoundQ16;

      unique case (state_ff)
         etap_pkg::BK_IDLE: begin
            if (!queue_status.empty) begin
               if (head.kind == etap_pkg::KIND_TAPER) begin
                  pop       = 1'b1;
                  k_in      = head.k;
                  frac_in   = head.frac;
                  blend_in  = head.blend;
                  pixel_in  = head.pixel;
                  fend_in   = head.frame_end;
                  second_in = 1'b0;
                  state_in  = etap_pkg::BK_T;
               end else if (out_free) begin
                  // Pass and zero requests leave straight from the queue head.
                  pop                       = 1'b1;
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.frame_end     = head.frame_end;
                  rsp_data_in.tapered_value =
                     (head.kind == etap_pkg::KIND_ZERO) ? '0 : head.pixel;
               end
            end
         end
         etap_pkg::BK_T: begin
            t_in     = (prod[ProdW-1:16] != '0) ? etap_pkg::OneQ16 : WW'(prod[15:0]);
            state_in = etap_pkg::BK_T2;
         end
         etap_pkg::BK_T2: begin
            t2_in    = prod[32:16];
            state_in = etap_pkg::BK_W;
         end
         etap_pkg::BK_W: begin
            if (second_ff) begin
               w1_in    = w_new;
               state_in = etap_pkg::BK_BLEND0;
            end else if (blend_ff) begin
               w0_in     = w_new;
               k_in      = k_ff + etap_pkg::KW'(1);
               second_in = 1'b1;
               state_in  = etap_pkg::BK_T;
            end else begin
               wt_in    = w_new;
               state_in = etap_pkg::BK_SCALE;
            end
         end
         etap_pkg::BK_BLEND0: begin
            acc_in   = prod[AccW-1:0];
            state_in = etap_pkg::BK_BLEND1;
         end
         etap_pkg::BK_BLEND1: begin
            wt_in    = blend_sum[20:4];
            state_in = etap_pkg::BK_SCALE;
         end
         etap_pkg::BK_SCALE: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.frame_end     = fend_ff;
               rsp_data_in.tapered_value =
                  (scaled[33:16] > 18'(etap_pkg::PixelMax)) ? etap_pkg::PixelMax
                                                            : scaled[31:16];
               state_in = etap_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = etap_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etap_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      frac_ff     <= frac_in;
      blend_ff    <= blend_in;
      second_ff   <= second_in;
      pixel_ff    <= pixel_in;
      fend_ff     <= fend_in;
      t_ff        <= t_in;
      t2_ff       <= t2_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      acc_ff      <= acc_in;
      wt_ff       <= wt_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hdl/edge_taper_apodization.sv -----
// Edge taper apodization: smoothstep border weighting of a raster pixel stream.
// Pass-through and zero pixels leave straight from the queue head; a full-mode taper pixel
//   runs the states T, T2, W and SCALE, a masked-mode one T, T2, W twice (two weights), then BLEND0, BLEND1, SCALE.
// Throughput: one pixel per cycle outside the taper while the sink does not stall; inside it the
//   single shared multiplier takes one pixel at a time; a full queue stalls the input.
// Reset: synchronous, active high; clears counters, queue, sequencer, output valid; 1 x 1 frame.
module edge_taper_apodization #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  etap_pkg::etap_req_type               req_data,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output etap_pkg::etap_rsp_type               rsp_data,

   input  logic                                 csr_write_en,
   input  logic [etap_pkg::CsrIndexW-1:0]       csr_index,
   input  logic [etap_pkg::CsrDataW-1:0]        csr_data
);

   etap_pkg::etap_cfg_type          cfg_ff, cfg_in;
   etap_pkg::etap_entry_type        push_entry, head;
   etap_pkg::etap_queue_status_type q_status;
   logic                            push, pop;

   // Register file: write-only, decoded by index; unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (etap_pkg::etap_reg_type'(csr_index))
            etap_pkg::REG_FRAME_WIDTH:   cfg_in.frame_width   = csr_data[etap_pkg::FrameDimW-1:0];
            etap_pkg::REG_FRAME_HEIGHT:  cfg_in.frame_height  = csr_data[etap_pkg::FrameDimW-1:0];
            etap_pkg::REG_TAPER_SIZE:    cfg_in.taper_size    = csr_data[etap_pkg::TaperW-1:0];
            etap_pkg::REG_TAPER_INVERSE: cfg_in.taper_inverse = csr_data[etap_pkg::InvW-1:0];
            etap_pkg::REG_MASKED_MODE:   cfg_in.masked_mode   = csr_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= etap_pkg::FrameDimW'(1);
         cfg_ff.frame_height  <= etap_pkg::FrameDimW'(1);
         cfg_ff.taper_size    <= '0;
         cfg_ff.taper_inverse <= '0;
         cfg_ff.masked_mode   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: track row and column, classify each request, push into the queue.
   etap_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (q_status.full),
      .req_stall  (req_stall),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue: decouple the counter side from the weight sequencer.
   etap_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // Back: compute the weight, scale the pixel, hold the result for the sink.
   etap_back u_back (
      .clock         (clock),
      .reset         (reset),
      .taper_inverse (cfg_ff.taper_inverse),
      .head          (head),
      .queue_status  (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

   // Queue occupancy stays within its depth.
   assert property (@(posedge clock) disable iff (reset)
      q_status.count <= etap_pkg::QueueCountW'(etap_pkg::QueueDepth))
      else $error("queue occupancy beyond depth");

   // Occupancy moves by exactly the pushes and pops of the previous cycle.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> q_status.count ==
         etap_pkg::QueueCountW'($past(q_status.count) +
            etap_pkg::QueueCountW'($past(push)) - etap_pkg::QueueCountW'($past(pop))))
      else $error("queue occupancy out of step with push and pop");

   // The back end never takes a request from an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule

// ----- dv/tb_top.sv -----
// Testbench for the edge taper apodization block: a table of directed requests, then random phases.
module tb_top;
   import etap_pkg::*;

   localparam int ClockHalf    = 6;
   localparam int ResetCycles  = 4;
   localparam int FrameMax     = 4096;
   localparam int QuietLimit   = 4000;
   localparam int HoldCycles   = 300;
   localparam int SettleCycles = 16;
   localparam int PhaseCount   = 14;
   localparam int PhaseLength  = 50;
   localparam int HoldPhase    = 4;
   localparam int DirectedRows = 23;
   localparam int PresetCount  = 6;

   // Idling pattern of the two channels for one phase
   typedef enum logic [1:0] {
      PACE_FREE     = 2'd0,
      PACE_SENDER   = 2'd1,
      PACE_RECEIVER = 2'd2,
      PACE_BOTH     = 2'd3
   } pace_type;

   // One directed request: the register preset it runs under, the request fields,
   // and a typed-in response where one can be read off directly.
   typedef struct packed {
      logic [2:0]        preset;
      logic [PixelW-1:0] pixel;
      logic [DistW-1:0]  edge_dist;
      logic              literal;
      logic [PixelW-1:0] want_value;
      logic              want_end;
   } vector_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_stall;
   etap_req_type         req_data     = '0;
   logic                 rsp_valid;
   logic                 rsp_stall    = 1'b0;
   etap_rsp_type         rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [CsrIndexW-1:0] csr_index    = '0;
   logic [CsrDataW-1:0]  csr_data     = '0;

   // Predictor copy of the registers and the raster position
   etap_cfg_type shadow_cfg;
   int unsigned  col_pos = 0;
   int unsigned  row_pos = 0;

   // Responses still owed by the block, oldest first
   etap_rsp_type pending_rsp [$];

   int       errors    = 0;
   int       quiet     = 0;
   int       hold_left = 0;
   logic     hold_go   = 1'b0;
   pace_type pace      = PACE_FREE;

   etap_cfg_type presets        [PresetCount];
   vector_type   directed_rows  [DirectedRows];

   edge_taper_apodization DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   initial begin
      forever #ClockHalf clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Clamp a frame dimension register into 1..FrameMax.
   function automatic int unsigned frame_dim(input logic [FrameDimW-1:0] v);
      if (v == '0) return 1;
      if (v > FrameMax) return FrameMax;
      return v;
   endfunction

   // Smoothstep weight at whole-pixel distance k, Q1.16, truncating at each step.
   function automatic logic [WeightW-1:0] smooth_weight(input int unsigned k);
      logic [63:0] t, t2, s, w;
      t = 64'(k) * 64'(shadow_cfg.taper_inverse);
      if (t > 64'(OneQ16)) t = 64'(OneQ16);
      t2 = (t * t) >> 16;
      s  = 64'(3) * 64'(OneQ16) - 64'(2) * t;
      w  = (t2 * s) >> 16;
      if (w > 64'(OneQ16)) w = 64'(OneQ16);
      return w[WeightW-1:0];
   endfunction

   // Pixel times Q1.16 weight, round half up, saturate to 16 bits.
   function automatic logic [PixelW-1:0] apply_weight(input logic [PixelW-1:0] pix,
                                                      input logic [WeightW-1:0] wt);
      logic [63:0] r;
      r = (64'(pix) * 64'(wt) + 64'd32768) >> 16;
      return (r > 64'(PixelMax)) ? PixelMax : r[PixelW-1:0];
   endfunction

   // Tapered response for one pixel; advances the raster position.
   function automatic etap_rsp_type taper_pixel(input etap_req_type req);
      etap_rsp_type        rsp;
      int unsigned         wd, ht, right, bottom, d, idx, frac;
      logic [WeightW-1:0]  w0, w1;
      logic [63:0]         mix;
      logic                end_col, end_row;
      wd      = frame_dim(shadow_cfg.frame_width);
      ht      = frame_dim(shadow_cfg.frame_height);
      end_col = (col_pos + 1 >= wd);
      end_row = (row_pos + 1 >= ht);
      rsp.tapered_value = req.pixel_value;
      if (shadow_cfg.taper_size != '0) begin
         if (shadow_cfg.masked_mode) begin
            if (req.edge_distance == '0) begin
               rsp.tapered_value = '0;
            end else begin
               idx  = req.edge_distance >> FracW;
               frac = req.edge_distance & 16'hF;
               if (idx < shadow_cfg.taper_size) begin
                  w0  = smooth_weight(idx);
                  w1  = smooth_weight(idx + 1);
                  mix = (64'(w0) * 64'(16 - frac) + 64'(w1) * 64'(frac)) >> 4;
                  rsp.tapered_value = apply_weight(req.pixel_value, mix[WeightW-1:0]);
               end
            end
         end else begin
            // Past the far edge (frame shrunk mid-frame) counts as distance 0
            right  = (col_pos < wd) ? wd - 1 - col_pos : 0;
            bottom = (row_pos < ht) ? ht - 1 - row_pos : 0;
            d = col_pos;
            if (right < d) d = right;
            if (row_pos < d) d = row_pos;
            if (bottom < d) d = bottom;
            if (d < shadow_cfg.taper_size)
               rsp.tapered_value = apply_weight(req.pixel_value, smooth_weight(d));
         end
      end
      rsp.frame_end = end_col && end_row;
      if (end_col) begin
         col_pos = 0;
         row_pos = end_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   // Count one mismatch and print it on one line.
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      errors++;
      $display("tb_top: mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
   endtask

   // Compare one accepted response with the oldest pending one.
   task automatic check_response(input etap_rsp_type got);
      etap_rsp_type want;
      if (pending_rsp.size() == 0) begin
         report_mismatch("response with nothing pending", got.tapered_value, 0);
      end else begin
         want = pending_rsp.pop_front();
         if (got.tapered_value !== want.tapered_value)
            report_mismatch("tapered_value", got.tapered_value, want.tapered_value);
         if (got.frame_end !== want.frame_end)
            report_mismatch("frame_end", got.frame_end, want.frame_end);
      end
   endtask

   // Sample both channels at the falling edge, where everything driven at the
   // rising edge has settled; a handshake seen here completes at the next rise.
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) check_response(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= QuietLimit) begin
            $display("tb_top: watchdog, nothing moved for %0d cycles", QuietLimit);
            $display("tb_top: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver side
   // ---------------------------------------------------------------------

   function automatic bit receiver_rests();
      case (pace)
         PACE_RECEIVER: return $urandom_range(0, 99) < 62;
         PACE_BOTH:     return $urandom_range(0, 99) < 15;
         default:       return 1'b0;
      endcase
   endfunction

   // Stall at random per the pace; a hold pulse starts a long hold-off counted here.
   always @(posedge clock) begin
      if (hold_go) hold_left = HoldCycles;
      else if (hold_left > 0) hold_left = hold_left - 1;
      rsp_stall <= (hold_left > 0) || receiver_rests();
   end

   // ---------------------------------------------------------------------
   // Sender side and register port (all tasks are entered at a rising edge)
   // ---------------------------------------------------------------------

   function automatic bit sender_rests();
      case (pace)
         PACE_SENDER: return $urandom_range(0, 99) < 62;
         PACE_BOTH:   return $urandom_range(0, 99) < 15;
         default:     return 1'b0;
      endcase
   endfunction

   // Offer one request, hold it until taken, and log what it should produce.
   task automatic send_request(input etap_req_type req, input logic literal,
                               input etap_rsp_type typed);
      bit           took;
      etap_rsp_type guess;
      while (sender_rests()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do begin
         @(negedge clock);
         took = !req_stall;
         if (took) begin
            // Run the predictor regardless so the raster position stays in step
            guess = taper_pixel(req);
            pending_rsp.push_back(literal ? typed : guess);
         end
         @(posedge clock);
      end while (!took);
   endtask

   // Drop valid, drain every pending response, then let the back end go quiet.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input etap_reg_type idx, input logic [CsrDataW-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= value;
      case (idx)
         REG_FRAME_WIDTH:   shadow_cfg.frame_width   = value[FrameDimW-1:0];
         REG_FRAME_HEIGHT:  shadow_cfg.frame_height  = value[FrameDimW-1:0];
         REG_TAPER_SIZE:    shadow_cfg.taper_size    = value[TaperW-1:0];
         REG_TAPER_INVERSE: shadow_cfg.taper_inverse = value[InvW-1:0];
         REG_MASKED_MODE:   shadow_cfg.masked_mode   = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Write every register; only called with the block drained.
   task automatic program_regs(input etap_cfg_type cfg);
      write_reg(REG_FRAME_WIDTH,   CsrDataW'(cfg.frame_width));
      write_reg(REG_FRAME_HEIGHT,  CsrDataW'(cfg.frame_height));
      write_reg(REG_TAPER_SIZE,    CsrDataW'(cfg.taper_size));
      write_reg(REG_TAPER_INVERSE, CsrDataW'(cfg.taper_inverse));
      write_reg(REG_MASKED_MODE,   CsrDataW'(cfg.masked_mode));
      csr_write_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Random content
   // ---------------------------------------------------------------------

   // Mostly small frames so frame ends come often; sometimes the clamp cases.
   function automatic logic [FrameDimW-1:0] random_dim();
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return 13'd4096;
         2:       return 13'h1FFF;
         3:       return FrameDimW'($urandom);
         default: return FrameDimW'($urandom_range(1, 9));
      endcase
   endfunction

   function automatic etap_cfg_type random_setting(input int phase);
      etap_cfg_type cfg;
      cfg.frame_width  = random_dim();
      cfg.frame_height = random_dim();
      cfg.taper_size   = ($urandom_range(0, 5) == 0) ? '0 : TaperW'($urandom_range(1, 6));
      if ($urandom_range(0, 7) == 0) cfg.taper_size = 10'd1023;
      // Correct reciprocal most of the time, else out-of-range or junk inverses
      cfg.taper_inverse = (cfg.taper_size == '0) ? '0 : InvW'(65536 / cfg.taper_size);
      case ($urandom_range(0, 9))
         0:       cfg.taper_inverse = '0;
         1:       cfg.taper_inverse = 17'h1FFFF;
         2:       cfg.taper_inverse = InvW'($urandom);
         default: ;
      endcase
      cfg.masked_mode = 1'($urandom_range(0, 1));
      // Pin the extremes in the first phases
      case (phase)
         0: cfg = '{13'd4096, 13'd1, 10'd1023, 17'd64, 1'b0};
         1: cfg = '{13'd1, 13'd4096, 10'd1023, 17'd64, 1'b1};
         2: cfg.taper_size = '0;
         3: cfg = '{13'h1FFF, 13'h1FFF, 10'd3, 17'h10000, 1'b0};
         default: ;
      endcase
      return cfg;
   endfunction

   function automatic etap_req_type random_request();
      etap_req_type req;
      case ($urandom_range(0, 7))
         0:       req.pixel_value = PixelMax;
         1:       req.pixel_value = '0;
         default: req.pixel_value = PixelW'($urandom);
      endcase
      // In masked mode aim most distances at the taper band and just past it
      if (shadow_cfg.masked_mode && $urandom_range(0, 9) > 1)
         req.edge_distance = {IdxW'($urandom_range(0, shadow_cfg.taper_size + 1)),
                              FracW'($urandom_range(0, 15))};
      else if ($urandom_range(0, 9) == 0)
         req.edge_distance = '0;
      else
         req.edge_distance = DistW'($urandom);
      return req;
   endfunction

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      etap_req_type req;
      etap_rsp_type typed;
      vector_type   row;
      int           current;

      // Register presets for the directed table; preset 0 is the reset state.
      presets = '{
         '{13'd1, 13'd1,      10'd0,    17'd0,       1'b0},
         '{13'd3, 13'd3,      10'd1,    17'h10000,   1'b0},
         '{13'd1, 13'd1,      10'd1023, 17'd64,      1'b1},
         '{13'd1, 13'd1,      10'd5,    17'd0,       1'b1},
         '{13'd1, 13'd1,      10'd1023, 17'h10000,   1'b1},
         '{13'd0, 13'h1FFF,   10'd1023, 17'd64,      1'b0}
      };

      directed_rows = '{
         // After reset: 1 x 1 frame, taper off, every pixel ends a frame
         '{3'd0, 16'hFFFF, 16'h0000, 1'b1, 16'hFFFF, 1'b1},
         '{3'd0, 16'h0000, 16'hFFFF, 1'b1, 16'h0000, 1'b1},
         // 3 x 3 full mode, taper 1: border weight is zero, center passes
         '{3'd1, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 1'b0},
         '{3'd1, 16'h8000, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
         '{3'd1, 16'h0001, 16'h0000, 1'b1, 16'h0000, 1'b0},
         '{3'd1, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 1'b0},
         '{3'd1, 16'h1234, 16'h0000, 1'b1, 16'h1234, 1'b0},
         '{3'd1, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 1'b0},
         '{3'd1, 16'h7FFF, 16'h0000, 1'b1, 16'h0000, 1'b0},
         '{3'd1, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 1'b0},
         '{3'd1, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 1'b1},
         // Masked, widest taper: zero distance, beyond the band, band edges
         '{3'd2, 16'hFFFF, 16'h0000, 1'b1, 16'h0000, 1'b1},
         '{3'd2, 16'hABCD, 16'hFFFF, 1'b1, 16'hABCD, 1'b1},
         '{3'd2, 16'hFFFF, 16'h3FEF, 1'b0, 16'h0000, 1'b0},
         '{3'd2, 16'hFFFF, 16'h3FF0, 1'b1, 16'hFFFF, 1'b1},
         '{3'd2, 16'hFFFF, 16'h0001, 1'b0, 16'h0000, 1'b0},
         '{3'd2, 16'h8000, 16'h0208, 1'b0, 16'h0000, 1'b0},
         // Masked with a zero inverse: weight zero inside, pass outside
         '{3'd3, 16'hFFFF, 16'h0010, 1'b1, 16'h0000, 1'b1},
         '{3'd3, 16'hFFFF, 16'h0050, 1'b1, 16'hFFFF, 1'b1},
         // Masked with an inverse of 1.0: t saturates, full weight from 1 up
         '{3'd4, 16'hFFFF, 16'h0018, 1'b1, 16'hFFFF, 1'b1},
         '{3'd4, 16'hFFFF, 16'h0008, 1'b0, 16'h0000, 1'b0},
         // Full mode, width 0 and height 8191 clamp to 1 and the maximum
         '{3'd5, 16'hFFFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
         '{3'd5, 16'h0001, 16'h0000, 1'b0, 16'h0000, 1'b0}
      };

      shadow_cfg = presets[0];

      // Hold reset, then release it at a rising edge
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; drain and reprogram whenever the preset changes
      current = 0;
      for (int i = 0; i < DirectedRows; i++) begin
         row = directed_rows[i];
         if (row.preset != current) begin
            wait_drained();
            program_regs(presets[row.preset]);
            current = row.preset;
         end
         req.pixel_value     = row.pixel;
         req.edge_distance   = row.edge_dist;
         typed.tapered_value = row.want_value;
         typed.frame_end     = row.want_end;
         send_request(req, row.literal, typed);
      end

      // Random phases: new registers and a new idling pattern each time.
      // Phases do not line up with frames, so shrinking a frame mid-frame
      // pushes the counters past the edge now and then.
      for (int phase = 0; phase < PhaseCount; phase++) begin
         wait_drained();
         pace <= pace_type'(phase % 4);
         if (phase == HoldPhase) hold_go <= 1'b1;
         program_regs(random_setting(phase));
         hold_go <= 1'b0;
         for (int n = 0; n < PhaseLength; n++)
            send_request(random_request(), 1'b0, '0);
      end

      // Drain what is still in flight, then give stray responses time to show
      wait_drained();

      if (errors == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/etap_pkg.sv
hdl/etap_front.sv
hdl/etap_queue.sv
hdl/etap_back.sv
hdl/edge_taper_apodization.sv
dv/tb_top.sv
